>>> rtl/sst_pkg.sv
package sst_pkg;

    // capacity and field widths
    localparam int MAX_ENTRIES = 64;
    localparam int FIELD_BITS  = 24;
    localparam int VALUE_BITS  = 64;
    localparam int SLOT_BITS   = $clog2(MAX_ENTRIES);
    localparam int COUNT_BITS  = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_BITS    = 2 * FIELD_BITS;

    // one matrix entry
    typedef struct packed {
        logic [FIELD_BITS-1:0] row;
        logic [FIELD_BITS-1:0] col;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    // what one cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   greater;
        entry_t entry;
    } link_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_FEED,
        ST_DRAIN
    } state_t;

    // sort key: primary field in the upper half
    function automatic logic [KEY_BITS-1:0] sort_key(input entry_t e, input logic by_col);
        logic [KEY_BITS-1:0] k;
        if (by_col)
        begin
            k = {e.col, e.row};
        end
        else
        begin
            k = {e.row, e.col};
        end
        return k;
    endfunction

endpackage

>>> rtl/sst_in_if.sv
interface sst_in_if;
    logic                           valid;
    logic                           ready;
    logic [sst_pkg::FIELD_BITS-1:0] row_index;
    logic [sst_pkg::FIELD_BITS-1:0] col_index;
    logic [sst_pkg::VALUE_BITS-1:0] value_bits;
    logic                           last_entry;

    modport source (
        output valid,
        input  ready,
        output row_index,
        output col_index,
        output value_bits,
        output last_entry
    );

    modport sink (
        input  valid,
        output ready,
        input  row_index,
        input  col_index,
        input  value_bits,
        input  last_entry
    );
endinterface

>>> rtl/sst_out_if.sv
interface sst_out_if;
    logic                           valid;
    logic                           ready;
    logic [sst_pkg::FIELD_BITS-1:0] row_out;
    logic [sst_pkg::FIELD_BITS-1:0] col_out;
    logic [sst_pkg::VALUE_BITS-1:0] value_out;
    logic                           last_out;
    logic                           overflow;

    modport source (
        output valid,
        input  ready,
        output row_out,
        output col_out,
        output value_out,
        output last_out,
        output overflow
    );

    modport sink (
        input  valid,
        output ready,
        input  row_out,
        input  col_out,
        input  value_out,
        input  last_out,
        input  overflow
    );
endinterface

>>> rtl/sst_ram.sv
module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sst_cell.sv
module sst_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            by_col,
    input  logic            insert,
    input  logic            shift,
    input  sst_pkg::entry_t new_entry,
    input  sst_pkg::link_t  prev_link,
    input  sst_pkg::link_t  next_link,
    output sst_pkg::link_t  link
);
    import sst_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   greater;

    // held entry sorts after the one being inserted
    assign greater = valid_reg
                   && (sort_key(entry_reg, by_col) > sort_key(new_entry, by_col));

    // insert moves toward the tail, drain moves toward the head
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (insert)
        begin
            if (prev_link.greater)
            begin
                valid_next = 1'b1;
                entry_next = prev_link.entry;
            end
            else if (prev_link.valid && (greater || !valid_reg))
            begin
                valid_next = 1'b1;
                entry_next = new_entry;
            end
        end
        else if (shift)
        begin
            valid_next = next_link.valid;
            entry_next = next_link.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign link.valid   = valid_reg;
    assign link.greater = greater;
    assign link.entry   = entry_reg;

endmodule

>>> rtl/sparse_entry_two_key_sorter.sv
// loading: one entry per cycle, no result for an entry not marked last
// after the last-marked beat: the entry memory is streamed into the insertion
// chain, then n results, one per cycle while ready is high (n = stored entries, 1..64)
// the next set is taken once the final result beat has gone out
// reset: asynchronous active low, empties the chain and the entry count,
// clears the overflow flag and sets sort order to row then column
module sparse_entry_two_key_sorter (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_we,
    input  logic     cfg_wdata,
    sst_in_if.sink   in_ch,
    sst_out_if.source out_ch
);
    import sst_pkg::*;

    state_t                state_reg;
    state_t                state_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] rd_ptr_reg;
    logic [COUNT_BITS-1:0] rd_ptr_next;
    logic                  ins_reg;
    logic                  ins_next;
    logic                  dropped_reg;
    logic                  dropped_next;
    logic                  by_col_reg;

    logic   in_beat;
    logic   out_beat;
    logic   full;
    logic   mem_we;
    entry_t mem_wdata;
    entry_t mem_rdata;
    logic   shift;

    link_t  links [MAX_ENTRIES];
    link_t  head_prev;
    link_t  tail_next;

    assign full      = (count_reg == COUNT_BITS'(MAX_ENTRIES));
    assign in_beat   = in_ch.valid && in_ch.ready;
    assign out_beat  = out_ch.valid && out_ch.ready;
    assign mem_we    = in_beat && !full;
    assign mem_wdata = '{row: in_ch.row_index, col: in_ch.col_index, value: in_ch.value_bits};

    // sort order register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            by_col_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            by_col_reg <= cfg_wdata;
        end
    end

    // entries in arrival order
    sst_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[SLOT_BITS-1:0]),
        .wdata (mem_wdata),
        .raddr (rd_ptr_reg[SLOT_BITS-1:0]),
        .rdata (mem_rdata)
    );

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            rd_ptr_reg  <= '0;
            ins_reg     <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_ptr_reg  <= rd_ptr_next;
            ins_reg     <= ins_next;
            dropped_reg <= dropped_next;
        end
    end

    // next state and controls
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_ptr_next  = rd_ptr_reg;
        ins_next     = 1'b0;
        dropped_next = dropped_reg;
        in_ch.ready  = 1'b0;
        shift        = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ch.ready = 1'b1;
                if (in_beat)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + COUNT_BITS'(1);
                    end
                    if (in_ch.last_entry)
                    begin
                        rd_ptr_next = '0;
                        state_next  = ST_FEED;
                    end
                end
            end
            ST_FEED:
            begin
                if (rd_ptr_reg < count_reg)
                begin
                    rd_ptr_next = rd_ptr_reg + COUNT_BITS'(1);
                    ins_next    = 1'b1;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                shift = out_beat;
                if (out_beat && out_ch.last_out)
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // chain ends
    assign head_prev = '{valid: 1'b1, greater: 1'b0, entry: '0};
    assign tail_next = '{valid: 1'b0, greater: 1'b0, entry: '0};

    // insertion chain, smallest key at cell 0
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        link_t prev_l;
        link_t next_l;

        if (i == 0)
        begin : g_head
            assign prev_l = head_prev;
        end
        else
        begin : g_body
            assign prev_l = links[i-1];
        end

        if (i == MAX_ENTRIES - 1)
        begin : g_tail
            assign next_l = tail_next;
        end
        else
        begin : g_mid
            assign next_l = links[i+1];
        end

        sst_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .by_col    (by_col_reg),
            .insert    (ins_reg),
            .shift     (shift),
            .new_entry (mem_rdata),
            .prev_link (prev_l),
            .next_link (next_l),
            .link      (links[i])
        );
    end

    // results come straight from the head cell
    assign out_ch.valid     = (state_reg == ST_DRAIN) && links[0].valid;
    assign out_ch.row_out   = links[0].entry.row;
    assign out_ch.col_out   = links[0].entry.col;
    assign out_ch.value_out = links[0].entry.value;
    assign out_ch.last_out  = !links[1].valid;
    assign out_ch.overflow  = dropped_reg;

endmodule

>>> tb/sv/sparse_entry_two_key_sorter_test.sv
`timescale 1ns / 1ps

module sparse_entry_two_key_sorter_test;
    import sst_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_PCT    = 26;
    localparam int SHOWN_LIMIT = 10;

    // one input beat waiting to be driven
    typedef struct {
        entry_t entry;
        logic   last;
    } entry_beat_t;

    // one sorted entry the block owes us
    typedef struct {
        logic [FIELD_BITS-1:0] row;
        logic [FIELD_BITS-1:0] col;
        logic [VALUE_BITS-1:0] value;
        logic                  last;
        logic                  overflow;
    } sorted_entry_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // locally held drive values, known from time zero
    logic                  cfg_we_r     = 1'b0;
    logic                  cfg_wdata_r  = 1'b0;
    logic                  in_valid_r   = 1'b0;
    logic [FIELD_BITS-1:0] in_row_r     = '0;
    logic [FIELD_BITS-1:0] in_col_r     = '0;
    logic [VALUE_BITS-1:0] in_value_r   = '0;
    logic                  in_last_r    = 1'b0;
    logic                  out_ready_r  = 1'b0;

    sst_in_if  in_ch ();
    sst_out_if out_ch ();

    assign in_ch.valid      = in_valid_r;
    assign in_ch.row_index  = in_row_r;
    assign in_ch.col_index  = in_col_r;
    assign in_ch.value_bits = in_value_r;
    assign in_ch.last_entry = in_last_r;
    assign out_ch.ready     = out_ready_r;

    sparse_entry_two_key_sorter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we_r),
        .cfg_wdata (cfg_wdata_r),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // beats not yet driven, entries of the open set, sorted entries still due
    entry_beat_t   pending_beats[$];
    entry_t        held_entries[$];
    sorted_entry_t sorted_due[$];
    logic          entries_lost = 1'b0;
    logic          by_column    = 1'b0;

    int  beats_queued   = 0;
    int  beats_taken    = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  calm           = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    // ordering key for the current mode, primary field on top
    function automatic logic [KEY_BITS-1:0] order_key(entry_t e);
        if (by_column)
        begin
            return {e.col, e.row};
        end
        return {e.row, e.col};
    endfunction

    // store one accepted entry; on the last mark, sort the set stably
    task automatic take_entry(entry_t e, logic is_last);
        entry_t        order[$];
        entry_t        hold;
        sorted_entry_t r;
        int            i;
        int            j;
        if (held_entries.size() < MAX_ENTRIES)
        begin
            held_entries = {held_entries, e};
        end
        else
        begin
            entries_lost = 1'b1;
        end
        if (is_last)
        begin
            order = held_entries;
            for (i = 1; i < order.size(); i++)
            begin
                hold = order[i];
                j = i;
                while (j > 0 && order_key(order[j-1]) > order_key(hold))
                begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = hold;
            end
            for (i = 0; i < order.size(); i++)
            begin
                r.row      = order[i].row;
                r.col      = order[i].col;
                r.value    = order[i].value;
                r.last     = (i == order.size() - 1);
                r.overflow = entries_lost;
                sorted_due = {sorted_due, r};
            end
            held_entries.delete();
            entries_lost = 1'b0;
        end
    endtask

    // input driver: record the accepted beat, then offer the next one
    always @(posedge clk)
    begin : drive_entries
        entry_beat_t b;
        if (!rst_n)
        begin
            in_valid_r <= 1'b0;
        end
        else
        begin
            if (in_valid_r && in_ch.ready)
            begin
                b.entry.row   = in_row_r;
                b.entry.col   = in_col_r;
                b.entry.value = in_value_r;
                take_entry(b.entry, in_last_r);
                beats_taken++;
            end
            if (!in_valid_r || in_ch.ready)
            begin
                if (pending_beats.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    b = pending_beats.pop_front();
                    in_valid_r <= 1'b1;
                    in_row_r   <= b.entry.row;
                    in_col_r   <= b.entry.col;
                    in_value_r <= b.entry.value;
                    in_last_r  <= b.last;
                end
                else
                begin
                    in_valid_r <= 1'b0;
                end
            end
        end
    end

    // output monitor: compare each result beat with the oldest sorted entry due
    always @(posedge clk)
    begin : watch_results
        sorted_entry_t e;
        if (!rst_n)
        begin
            out_ready_r <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ready_r)
            begin
                if (sorted_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_LIMIT)
                    begin
                        $display("unexpected result beat: row %h col %h value %h last %b ovf %b",
                                 out_ch.row_out, out_ch.col_out, out_ch.value_out,
                                 out_ch.last_out, out_ch.overflow);
                    end
                end
                else
                begin
                    e = sorted_due.pop_front();
                    if (out_ch.row_out !== e.row || out_ch.col_out !== e.col ||
                        out_ch.value_out !== e.value || out_ch.last_out !== e.last ||
                        out_ch.overflow !== e.overflow)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= SHOWN_LIMIT)
                        begin
                            $display("result mismatch: expected row %h col %h value %h last %b ovf %b",
                                     e.row, e.col, e.value, e.last, e.overflow);
                            $display("                 actual   row %h col %h value %h last %b ovf %b",
                                     out_ch.row_out, out_ch.col_out, out_ch.value_out,
                                     out_ch.last_out, out_ch.overflow);
                        end
                    end
                end
            end
            out_ready_r <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sparse_entry_two_key_sorter verification failed");
            $finish;
        end
    end

    task automatic queue_entry(logic [FIELD_BITS-1:0] row, logic [FIELD_BITS-1:0] col,
                               logic [VALUE_BITS-1:0] value, logic last);
        entry_beat_t b;
        b.entry.row   = row;
        b.entry.col   = col;
        b.entry.value = value;
        b.last        = last;
        pending_beats = {pending_beats, b};
        beats_queued++;
    endtask

    // mix of tiny values for key collisions, field extremes and full range
    function automatic logic [FIELD_BITS-1:0] pick_index();
        case ($urandom_range(0, 3))
            0: return FIELD_BITS'($urandom_range(0, 7));
            1: return $urandom_range(0, 1) ? '1 : '0;
            default: return FIELD_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_random_set(int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            queue_entry(pick_index(), pick_index(), pick_value(), i == count - 1);
        end
    endtask

    // mixed keys, ties on both keys and on one key, field extremes
    task automatic queue_tie_set();
        queue_entry(24'd5, 24'd3, 64'h1111_0000_0000_0001, 1'b0);
        queue_entry(24'd5, 24'd3, 64'h2222_0000_0000_0002, 1'b0);
        queue_entry(24'd2, 24'd9, 64'h3333_0000_0000_0003, 1'b0);
        queue_entry(24'd5, 24'd1, 64'h4444_0000_0000_0004, 1'b0);
        queue_entry(24'd0, 24'hFFFFFF, 64'h5555_0000_0000_0005, 1'b0);
        queue_entry(24'hFFFFFF, 24'd0, 64'h6666_0000_0000_0006, 1'b1);
    endtask

    // wait until every beat is in and every sorted entry is out
    task automatic wait_quiet();
        while (pending_beats.size() != 0 || beats_taken != beats_queued ||
               sorted_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // sort-order write, only between sets
    task automatic write_order(logic by_col);
        wait_quiet();
        repeat (4) @(posedge clk);
        cfg_we_r    <= 1'b1;
        cfg_wdata_r <= by_col;
        @(posedge clk);
        cfg_we_r    <= 1'b0;
        by_column    = by_col;
        @(posedge clk);
    endtask

    // stimulus sequencing
    initial
    begin : run_phases
        int phase;
        int phase_beats;
        int set_size;
        int pick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sets, row-major from reset
        queue_entry('1, '1, '1, 1'b1);
        queue_entry('0, '0, '0, 1'b1);
        queue_tie_set();
        write_order(1'b1);
        queue_tie_set();

        // random phases, order mostly alternating (random in phase 4), one without idling
        for (phase = 0; phase < 6; phase++)
        begin
            if (phase == 4)
            begin
                write_order(1'($urandom_range(0, 1)));
            end
            else
            begin
                write_order(phase % 2 == 0 ? 1'b0 : 1'b1);
            end
            calm = (phase == 3);
            phase_beats = 0;
            if (phase == 0)
            begin
                queue_random_set(MAX_ENTRIES + 2);
                phase_beats += MAX_ENTRIES + 2;
            end
            if (phase == 1)
            begin
                queue_random_set(MAX_ENTRIES);
                phase_beats += MAX_ENTRIES;
            end
            while (phase_beats < 65)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                begin
                    set_size = $urandom_range(MAX_ENTRIES, MAX_ENTRIES + 6);
                end
                else if (pick < 10)
                begin
                    set_size = $urandom_range(20, MAX_ENTRIES - 1);
                end
                else
                begin
                    set_size = $urandom_range(1, 12);
                end
                queue_random_set(set_size);
                phase_beats += set_size;
            end
        end

        wait_quiet();
        calm = 1'b0;
        repeat (2 * MAX_ENTRIES + 8) @(posedge clk);
        if (sorted_due.size() != 0)
        begin
            mismatch_count++;
        end
        if (mismatch_count == 0)
        begin
            $display("sparse_entry_two_key_sorter verification clean");
        end
        else
        begin
            $display("sparse_entry_two_key_sorter verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/sst_pkg.sv
rtl/sst_in_if.sv
rtl/sst_out_if.sv
rtl/sst_ram.sv
rtl/sst_cell.sv
rtl/sparse_entry_two_key_sorter.sv
tb/sv/sparse_entry_two_key_sorter_test.sv
